FILE: rtl/sfr_pkg.sv
// shared constants and types for the stream find-and-replace block
// no dependencies
`default_nettype none

package sfr_pkg;

  localparam int PATTERN_MAX_DEF     = 16;
  localparam int REPLACEMENT_MAX_DEF = 16;
  localparam int COUNT_BITS_DEF      = 16;

  localparam int LEN_BITS    = 5;
  localparam int MP_BITS     = 4;
  localparam int MCOUNT_BITS = 16;
  localparam int ADDR_BITS   = 6;
  localparam int DATA_BITS   = 64;

  typedef logic [7:0] byte_t;

  // one queued job: pattern prefix to flush, then a literal, the replacement or nothing
  typedef struct packed {
    byte_t                  data;
    logic [MP_BITS-1:0]     pre;
    logic                   lit;
    logic                   rep;
    logic                   done;
    logic [MCOUNT_BITS-1:0] count;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/sfr_in_if.sv
// input byte channel of the stream find-and-replace block
// no dependencies
`default_nettype none

interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, data_byte, end_of_string, input ready);
  modport sink (input valid, data_byte, end_of_string, output ready);
endinterface

`default_nettype wire

FILE: rtl/sfr_out_if.sv
// result channel of the stream find-and-replace block
// no dependencies
`default_nettype none

interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last_of_run;
  logic        string_done;
  logic [15:0] match_count;

  modport source (output valid, out_byte, byte_valid, last_of_run, string_done, match_count,
                  input ready);
  modport sink (input valid, out_byte, byte_valid, last_of_run, string_done, match_count,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/sfr_cfg.sv
// apb register file: pattern and replacement lengths and bytes
// depends on sfr_pkg
`default_nettype none

module sfr_cfg #(
  parameter int PATTERN_MAX     = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACEMENT_MAX = sfr_pkg::REPLACEMENT_MAX_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [sfr_pkg::ADDR_BITS-1:0]        paddr,
  input  wire logic [sfr_pkg::DATA_BITS-1:0]        pwdata,
  output logic      [sfr_pkg::DATA_BITS-1:0]        prdata,
  output logic                                      pready,
  output logic      [sfr_pkg::LEN_BITS-1:0]         plen,
  output logic      [sfr_pkg::LEN_BITS-1:0]         rlen,
  output logic      [PATTERN_MAX-1:0][7:0]          pat,
  output logic      [REPLACEMENT_MAX-1:0][7:0]      rpl
);

  typedef enum logic [2:0] {
    REG_PATTERN_LENGTH     = 3'd0,
    REG_PATTERN_LOW        = 3'd1,
    REG_PATTERN_HIGH       = 3'd2,
    REG_REPLACEMENT_LENGTH = 3'd3,
    REG_REPLACEMENT_LOW    = 3'd4,
    REG_REPLACEMENT_HIGH   = 3'd5
  } reg_idx_t;

  localparam logic [sfr_pkg::LEN_BITS-1:0] PMAX = sfr_pkg::LEN_BITS'(PATTERN_MAX);
  localparam logic [sfr_pkg::LEN_BITS-1:0] RMAX = sfr_pkg::LEN_BITS'(REPLACEMENT_MAX);

  logic [sfr_pkg::LEN_BITS-1:0]  plen_raw;
  logic [sfr_pkg::LEN_BITS-1:0]  rlen_raw;
  logic [sfr_pkg::DATA_BITS-1:0] pat_lo, pat_hi, rpl_lo, rpl_hi;
  reg_idx_t                      idx;
  logic                          wr;

  assign idx    = reg_idx_t'(paddr[sfr_pkg::ADDR_BITS-1:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plen_raw <= '0;
      rlen_raw <= '0;
      pat      <= '0;
      rpl      <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_PATTERN_LENGTH: plen_raw <= pwdata[sfr_pkg::LEN_BITS-1:0];
        REG_PATTERN_LOW: begin
          for (int i = 0; i < PATTERN_MAX; i++)
            if (i < 8) pat[i] <= pwdata[8*(i%8) +: 8];
        end
        REG_PATTERN_HIGH: begin
          for (int i = 0; i < PATTERN_MAX; i++)
            if (i >= 8) pat[i] <= pwdata[8*(i%8) +: 8];
        end
        REG_REPLACEMENT_LENGTH: rlen_raw <= pwdata[sfr_pkg::LEN_BITS-1:0];
        REG_REPLACEMENT_LOW: begin
          for (int i = 0; i < REPLACEMENT_MAX; i++)
            if (i < 8) rpl[i] <= pwdata[8*(i%8) +: 8];
        end
        REG_REPLACEMENT_HIGH: begin
          for (int i = 0; i < REPLACEMENT_MAX; i++)
            if (i >= 8) rpl[i] <= pwdata[8*(i%8) +: 8];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    pat_lo = '0;
    pat_hi = '0;
    rpl_lo = '0;
    rpl_hi = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i < 8) pat_lo[8*(i%8) +: 8] = pat[i];
      else       pat_hi[8*(i%8) +: 8] = pat[i];
    end
    for (int i = 0; i < REPLACEMENT_MAX; i++) begin
      if (i < 8) rpl_lo[8*(i%8) +: 8] = rpl[i];
      else       rpl_hi[8*(i%8) +: 8] = rpl[i];
    end
  end

  always_comb begin
    unique case (idx)
      REG_PATTERN_LENGTH:     prdata = sfr_pkg::DATA_BITS'(plen_raw);
      REG_PATTERN_LOW:        prdata = pat_lo;
      REG_PATTERN_HIGH:       prdata = pat_hi;
      REG_REPLACEMENT_LENGTH: prdata = sfr_pkg::DATA_BITS'(rlen_raw);
      REG_REPLACEMENT_LOW:    prdata = rpl_lo;
      REG_REPLACEMENT_HIGH:   prdata = rpl_hi;
      default:                prdata = '0;
    endcase
  end

  // oversized lengths act as the maximum
  assign plen = (plen_raw > PMAX) ? PMAX : plen_raw;
  assign rlen = (rlen_raw > RMAX) ? RMAX : rlen_raw;

endmodule

`default_nettype wire

FILE: rtl/sfr_front.sv
// front end: takes input bytes, tracks match progress and the count, queues jobs
// depends on sfr_pkg and sfr_in_if
`default_nettype none

module sfr_front #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
  parameter int COUNT_BITS  = sfr_pkg::COUNT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  sfr_in_if.sink                            text,
  input  wire logic [sfr_pkg::LEN_BITS-1:0] plen,
  input  wire logic [sfr_pkg::LEN_BITS-1:0] rlen,
  input  wire logic [PATTERN_MAX-1:0][7:0]  pat,
  input  wire logic                         fifo_full,
  output logic                              push,
  output sfr_pkg::cmd_t                     cmd
);

  localparam int PIW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [sfr_pkg::MP_BITS-1:0]  match_progress, match_progress_next;
  logic [COUNT_BITS-1:0]        replacements_made, replacements_made_next;
  logic [COUNT_BITS-1:0]        count_step;
  logic [sfr_pkg::LEN_BITS-1:0] mp_ext, mp_inc;
  logic [31:0]                  count_wide;
  logic                         hit, complete, take;

  assign text.ready = !fifo_full;
  assign take       = text.valid && text.ready;

  always_comb begin
    mp_ext   = sfr_pkg::LEN_BITS'(match_progress);
    mp_inc   = mp_ext + 1'b1;
    hit      = (mp_ext < plen) && (text.data_byte == pat[match_progress[PIW-1:0]]);
    complete = hit && (mp_inc == plen);

    cmd                 = '0;
    cmd.data            = text.data_byte;
    cmd.done            = text.end_of_string;
    match_progress_next = '0;
    count_step          = replacements_made;

    if (!hit) begin
      // mismatch: flush held prefix, then the byte itself
      cmd.pre = match_progress;
      cmd.lit = 1'b1;
    end else if (complete) begin
      cmd.rep = 1'b1;
      if (replacements_made != '1) count_step = replacements_made + 1'b1;
    end else begin
      match_progress_next = mp_inc[sfr_pkg::MP_BITS-1:0];
      if (text.end_of_string) cmd.pre = mp_inc[sfr_pkg::MP_BITS-1:0];
    end

    count_wide = 32'(count_step);
    if (text.end_of_string) begin
      cmd.count              = (count_wide > 32'hFFFF) ? '1 : count_wide[15:0];
      match_progress_next    = '0;
      replacements_made_next = '0;
    end else begin
      replacements_made_next = count_step;
    end

    push = take && (text.end_of_string || !hit || (complete && rlen != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_progress    <= '0;
      replacements_made <= '0;
    end else if (take) begin
      match_progress    <= match_progress_next;
      replacements_made <= replacements_made_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sfr_fifo.sv
// four-entry job queue between front end and emitter
// depends on sfr_pkg
`default_nettype none

module sfr_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  sfr_pkg::cmd_t      cmd_in,
  input  wire logic          pop,
  output sfr_pkg::cmd_t      head,
  output logic               avail,
  output logic               full
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  sfr_pkg::cmd_t   entries [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     fill;

  assign head  = entries[rd_ptr];
  assign avail = (fill != '0);
  assign full  = (fill == (AW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sfr_back.sv
// emitter: steps through each queued job one word a cycle into the output register while result is not stalled
// depends on sfr_pkg and sfr_out_if
`default_nettype none

module sfr_back #(
  parameter int PATTERN_MAX     = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACEMENT_MAX = sfr_pkg::REPLACEMENT_MAX_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  sfr_pkg::cmd_t                        head,
  input  wire logic                            avail,
  output logic                                 pop,
  input  wire logic [sfr_pkg::LEN_BITS-1:0]    rlen,
  input  wire logic [PATTERN_MAX-1:0][7:0]     pat,
  input  wire logic [REPLACEMENT_MAX-1:0][7:0] rpl,
  sfr_out_if.source                            result
);

  localparam int PIW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int RIW = (REPLACEMENT_MAX > 1) ? $clog2(REPLACEMENT_MAX) : 1;

  logic [sfr_pkg::LEN_BITS-1:0] k, n, pre_ext;
  logic                         last, load, has_byte;
  sfr_pkg::byte_t               sel;

  logic                         out_valid;
  sfr_pkg::byte_t               out_byte;
  logic                         byte_valid, last_of_run, string_done;
  logic [15:0]                  match_count;

  always_comb begin
    pre_ext  = sfr_pkg::LEN_BITS'(head.pre);
    n        = pre_ext + sfr_pkg::LEN_BITS'(head.lit) + (head.rep ? rlen : '0);
    has_byte = (n != '0);
    last     = !has_byte || (k == n - 1'b1);
    if (k < pre_ext)    sel = pat[k[PIW-1:0]];
    else if (head.lit)  sel = head.data;
    else if (has_byte)  sel = rpl[k[RIW-1:0]];
    else                sel = '0;
  end

  assign load = avail && (!out_valid || result.ready);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      k         <= last ? '0 : k + 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= sel;
      byte_valid  <= has_byte;
      last_of_run <= last;
      string_done <= last && head.done;
      match_count <= (last && head.done) ? head.count : '0;
    end
  end

  assign result.valid       = out_valid;
  assign result.out_byte    = out_byte;
  assign result.byte_valid  = byte_valid;
  assign result.last_of_run = last_of_run;
  assign result.string_done = string_done;
  assign result.match_count = match_count;

endmodule

`default_nettype wire

FILE: rtl/stream_find_and_replace.sv
// top level of the stream find-and-replace block
// depends on sfr_pkg, sfr_in_if, sfr_out_if, sfr_cfg, sfr_front, sfr_fifo, sfr_back
//
//   port     kind         word
//   text     valid/ready  data_byte, end_of_string
//   result   valid/ready  out_byte, byte_valid, last_of_run, string_done, match_count
//   apb      psel/penable 64-bit registers at 8*index
//
// a byte is taken every cycle while the four-entry job queue has room
// each byte gives 0 to 16 result words; the emitter sends one word a cycle
// while result.ready holds
// result words leave the emitter from its output register
// rst is synchronous and clears match state, count, queue and registers at once
`default_nettype none

module stream_find_and_replace #(
  parameter int PATTERN_MAX     = sfr_pkg::PATTERN_MAX_DEF,
  parameter int REPLACEMENT_MAX = sfr_pkg::REPLACEMENT_MAX_DEF,
  parameter int COUNT_BITS      = sfr_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  sfr_in_if.sink                             text,
  sfr_out_if.source                          result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sfr_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [sfr_pkg::DATA_BITS-1:0] pwdata,
  output logic      [sfr_pkg::DATA_BITS-1:0] prdata,
  output logic                               pready
);

  logic [sfr_pkg::LEN_BITS-1:0]   plen, rlen;
  logic [PATTERN_MAX-1:0][7:0]     pat;
  logic [REPLACEMENT_MAX-1:0][7:0] rpl;
  logic                            push, pop, avail, fifo_full;
  sfr_pkg::cmd_t                   cmd, head;

  sfr_cfg #(
    .PATTERN_MAX     (PATTERN_MAX),
    .REPLACEMENT_MAX (REPLACEMENT_MAX)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .plen    (plen),
    .rlen    (rlen),
    .pat     (pat),
    .rpl     (rpl)
  );

  sfr_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .plen      (plen),
    .rlen      (rlen),
    .pat       (pat),
    .fifo_full (fifo_full),
    .push      (push),
    .cmd       (cmd)
  );

  sfr_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .cmd_in (cmd),
    .pop    (pop),
    .head   (head),
    .avail  (avail),
    .full   (fifo_full)
  );

  sfr_back #(
    .PATTERN_MAX     (PATTERN_MAX),
    .REPLACEMENT_MAX (REPLACEMENT_MAX)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .avail  (avail),
    .pop    (pop),
    .rlen   (rlen),
    .pat    (pat),
    .rpl    (rpl),
    .result (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && fifo_full))
    else $error("job queue overflow");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail)
    else $error("pop from empty job queue");

  a_bare_marker_ends: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.byte_valid) |-> (result.string_done && result.last_of_run))
    else $error("bare end marker not at end of string");

  a_count_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.string_done) |-> (result.match_count == 16'd0))
    else $error("match count outside end of string");

endmodule

`default_nettype wire
